[src/egc_pkg.sv]
// Shared types and codes for the Elias gamma bitstream codec.
package egc_pkg;

  typedef enum logic [1:0] {
    OP_ENCODE = 2'd0,
    OP_FLUSH  = 2'd1,
    OP_DECODE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [3:0] FULL_BYTE_BITS = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ENC,
    ST_DEC,
    ST_FIN
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] value_in;
    logic [7:0]  byte_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic [3:0]  bits_valid;
    logic [31:0] value_out;
    logic        last;
  } out_item_t;

endpackage

[src/elias_gamma_bitstream_codec_top.sv]
// Elias gamma encoder and decoder over an MSB-first byte stream.
//
//   channel | direction | handshake                   | payload
//   input   | in        | in_valid_i / in_stall_o     | in_item_i  (op, value_in, byte_in)
//   output  | out       | out_valid_o / out_stall_i   | out_item_o (kind, byte_out, ...)
//
// One shared shift register and counter pair does the work, one code bit per unstalled cycle.
// Encode searches the msb in ST_SCAN, sends 2L+1 code bits in ST_ENC, drains in ST_FIN.
// Decode shifts 8 bits in ST_DEC then drains; flush and a zero-value error go to ST_FIN.
// Each result sits in a one-entry hold stage until the next one shows whether it is last.
// Output stalls pause the bit loop only when a produced result has nowhere to go.
// Reset is asynchronous and clears the sequencer and codec state; no clearing pass.
module elias_gamma_bitstream_codec_top
  import egc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int PW = (VALUE_WIDTH > 2) ? $clog2(VALUE_WIDTH) : 1;
  localparam logic [PW-1:0] PrefixMax = PW'(VALUE_WIDTH - 1);
  localparam logic [31:0] ValueMask =
    (VALUE_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << VALUE_WIDTH) - 64'd1);

  state_e state_q, state_d;

  logic [31:0]   shreg_q, shreg_d;
  logic [4:0]    pos_q, pos_d;
  logic [5:0]    rem_q, rem_d;
  logic [2:0]    bitcnt_q, bitcnt_d;

  logic [6:0]    enc_bits_q, enc_bits_d;
  logic [2:0]    enc_cnt_q, enc_cnt_d;

  logic          dec_suffix_q, dec_suffix_d;
  logic [PW-1:0] dec_prefix_q, dec_prefix_d;
  logic [PW-1:0] dec_left_q, dec_left_d;
  logic [31:0]   dec_accum_q, dec_accum_d;

  logic          hold_valid_q, hold_valid_d;
  out_item_t     hold_q, hold_d;

  logic          out_valid_q;
  out_item_t     out_q;

  logic          in_accept;
  logic          can_emit;
  logic [31:0]   masked_value;
  logic [7:0]    flush_byte;

  logic          step_bit;
  logic [7:0]    enc_word;
  logic [31:0]   accum_next;
  logic          res_valid;
  out_item_t     res_item;
  logic          step_go;

  logic          push;
  out_item_t     push_item;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_accept    = in_valid_i && !in_stall_o;
  assign can_emit     = !out_valid_q || !out_stall_i;
  assign masked_value = in_item_i.value_in & ValueMask;
  assign flush_byte   = 8'({1'b0, enc_bits_q} << (4'd8 - {1'b0, enc_cnt_q}));

  // Prefix ones while more than L+1 bits remain, then the zero, then the suffix bits.
  always_comb begin
    if (state_q == ST_ENC) begin
      if (rem_q > (6'(pos_q) + 6'd1)) begin
        step_bit = 1'b1;
      end else if (rem_q == (6'(pos_q) + 6'd1)) begin
        step_bit = 1'b0;
      end else begin
        step_bit = shreg_q[30];
      end
    end else begin
      step_bit = shreg_q[31];
    end
  end

  assign enc_word   = {enc_bits_q, step_bit};
  assign accum_next = {dec_accum_q[30:0], step_bit};

  // Result produced by the current bit step, before gating.
  always_comb begin
    res_valid = 1'b0;
    res_item  = '0;
    unique case (state_q)
      ST_ENC: begin
        if (enc_cnt_q == 3'd7) begin
          res_valid           = 1'b1;
          res_item.kind       = KIND_BYTE;
          res_item.byte_out   = enc_word;
          res_item.bits_valid = FULL_BYTE_BITS;
        end
      end
      ST_DEC: begin
        if (!dec_suffix_q) begin
          if (step_bit && (dec_prefix_q >= PrefixMax)) begin
            res_valid     = 1'b1;
            res_item.kind = KIND_ERROR;
          end else if (!step_bit && (dec_prefix_q == '0)) begin
            res_valid          = 1'b1;
            res_item.kind      = KIND_VALUE;
            res_item.value_out = 32'd1;
          end
        end else if (dec_left_q == PW'(1)) begin
          res_valid          = 1'b1;
          res_item.kind      = KIND_VALUE;
          res_item.value_out = accum_next;
        end
      end
      ST_IDLE, ST_SCAN, ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  assign step_go = !res_valid || !hold_valid_q || can_emit;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_item_i.op)
            OP_ENCODE: state_d = (masked_value == '0) ? ST_FIN : ST_SCAN;
            OP_DECODE: state_d = ST_DEC;
            OP_FLUSH:  state_d = ST_FIN;
            OP_NONE:   state_d = ST_FIN;
            default:   state_d = ST_FIN;
          endcase
        end
      end
      ST_SCAN: begin
        if (shreg_q[31]) state_d = ST_ENC;
      end
      ST_ENC: begin
        if (step_go && (rem_q == 6'd1)) state_d = ST_FIN;
      end
      ST_DEC: begin
        if (step_go && (bitcnt_q == '0)) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!hold_valid_q || can_emit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and result routing.
  always_comb begin
    shreg_d      = shreg_q;
    pos_d        = pos_q;
    rem_d        = rem_q;
    bitcnt_d     = bitcnt_q;
    enc_bits_d   = enc_bits_q;
    enc_cnt_d    = enc_cnt_q;
    dec_suffix_d = dec_suffix_q;
    dec_prefix_d = dec_prefix_q;
    dec_left_d   = dec_left_q;
    dec_accum_d  = dec_accum_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    push         = 1'b0;
    push_item    = hold_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_item_i.op)
            OP_ENCODE: begin
              shreg_d = masked_value;
              pos_d   = 5'd31;
              if (masked_value == '0) begin
                hold_valid_d = 1'b1;
                hold_d       = '0;
                hold_d.kind  = KIND_ERROR;
              end
            end
            OP_FLUSH: begin
              if (enc_cnt_q != '0) begin
                hold_valid_d      = 1'b1;
                hold_d            = '0;
                hold_d.kind       = KIND_BYTE;
                hold_d.byte_out   = flush_byte;
                hold_d.bits_valid = {1'b0, enc_cnt_q};
                enc_bits_d        = '0;
                enc_cnt_d         = '0;
              end
            end
            OP_DECODE: begin
              shreg_d  = {in_item_i.byte_in, 24'd0};
              bitcnt_d = 3'd7;
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (shreg_q[31]) begin
          rem_d = {pos_q, 1'b1};
        end else begin
          shreg_d = {shreg_q[30:0], 1'b0};
          pos_d   = pos_q - 5'd1;
        end
      end
      ST_ENC: begin
        if (step_go) begin
          rem_d = rem_q - 6'd1;
          if (rem_q <= 6'(pos_q)) shreg_d = {shreg_q[30:0], 1'b0};
          if (enc_cnt_q == 3'd7) begin
            enc_bits_d = '0;
            enc_cnt_d  = '0;
          end else begin
            enc_bits_d = enc_word[6:0];
            enc_cnt_d  = enc_cnt_q + 3'd1;
          end
        end
      end
      ST_DEC: begin
        if (step_go) begin
          shreg_d  = {shreg_q[30:0], 1'b0};
          bitcnt_d = bitcnt_q - 3'd1;
          if (!dec_suffix_q) begin
            if (step_bit) begin
              if (dec_prefix_q >= PrefixMax) begin
                dec_prefix_d = '0;
              end else begin
                dec_prefix_d = dec_prefix_q + PW'(1);
              end
            end else if (dec_prefix_q != '0) begin
              dec_suffix_d = 1'b1;
              dec_left_d   = dec_prefix_q;
              dec_accum_d  = 32'd1;
            end
          end else begin
            dec_accum_d = accum_next;
            dec_left_d  = dec_left_q - PW'(1);
            if (dec_left_q == PW'(1)) begin
              dec_suffix_d = 1'b0;
              dec_prefix_d = '0;
              dec_left_d   = '0;
              dec_accum_d  = '0;
            end
          end
        end
      end
      ST_FIN: begin
        if (hold_valid_q && can_emit) begin
          push           = 1'b1;
          push_item      = hold_q;
          push_item.last = 1'b1;
          hold_valid_d   = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // A new result shows that the held one is not the last of its item.
    if (res_valid && step_go && ((state_q == ST_ENC) || (state_q == ST_DEC))) begin
      if (hold_valid_q) begin
        push           = 1'b1;
        push_item      = hold_q;
        push_item.last = 1'b0;
      end
      hold_valid_d = 1'b1;
      hold_d       = res_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      enc_bits_q   <= '0;
      enc_cnt_q    <= '0;
      dec_suffix_q <= 1'b0;
      dec_prefix_q <= '0;
      dec_left_q   <= '0;
      dec_accum_q  <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      enc_bits_q   <= enc_bits_d;
      enc_cnt_q    <= enc_cnt_d;
      dec_suffix_q <= dec_suffix_d;
      dec_prefix_q <= dec_prefix_d;
      dec_left_q   <= dec_left_d;
      dec_accum_q  <= dec_accum_d;
      hold_valid_q <= hold_valid_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q  <= shreg_d;
    pos_q    <= pos_d;
    rem_q    <= rem_d;
    bitcnt_q <= bitcnt_d;
    hold_q   <= hold_d;
    if (push) out_q <= push_item;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[src/egc_checker.sv]
// Port-level checks for the Elias gamma codec, bound to its top level.
module egc_checker
  import egc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result payload changed while stalled");

  // Every accepted transaction occupies the block for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted back to back");

  // A partial byte only comes from a flush, which gives at most one result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_BYTE) && (out_item_o.bits_valid != FULL_BYTE_BITS)
      |-> out_item_o.last)
    else $error("partial byte not marked last");

endmodule

bind elias_gamma_bitstream_codec_top egc_checker u_egc_checker (.*);
